/* design/mts_pkg.sv */
// package for the min tracking stack
// widths, entry and shift-control types, opcodes; no dependencies
package mts_pkg;

  localparam int DEPTH      = 64;
  localparam int VALUE_BITS = 32;
  localparam int FIELD_BITS = 32;
  localparam int CNT_BITS   = $clog2(DEPTH + 1);

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_t;

  // one stack entry: value and minimum of the stack up to it
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [VALUE_BITS-1:0] min;
  } entry_t;

  // shift command broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

/* design/min_tracking_stack_top.sv */
// top level of the min tracking stack: fill counter, push/pop decode, result register
// uses mts_pkg and mts_chain
// Bounded LIFO stack (DEPTH entries) that reports its top value and minimum after
// every push or pop. The result of each accepted word is registered and shows in the
// output register in the cycle after it is taken; a new word is accepted every cycle
// while the result register is empty or being drained: one word per clock sustained.
// The stack is a chain of cells that all shift by one place in the same cycle, so
// the cost of an operation does not depend on the depth. No clearing pass after reset.
module min_tracking_stack_top import mts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  opcode,
  input  logic signed [31:0]    push_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    stack_top,
  output logic signed [31:0]    stack_min,
  output logic                  is_empty,
  output logic                  op_error
);

  logic [CNT_BITS-1:0] fill;
  logic [CNT_BITS-1:0] fill_next;
  logic                in_fire;
  logic                full;
  logic                empty;
  logic                do_push;
  logic                do_pop;
  shift_t              shift;
  entry_t              new_entry;
  entry_t              top_entry;
  entry_t              next_entry;
  entry_t              res_entry;
  logic                res_empty;
  logic [VALUE_BITS-1:0] val;

  assign in_ready = !rst && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;

  assign full    = (fill == CNT_BITS'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = (opcode_t'(opcode) == OP_PUSH) && !full;
  assign do_pop  = (opcode_t'(opcode) == OP_POP) && !empty;

  assign shift.push = in_fire && do_push;
  assign shift.pop  = in_fire && do_pop;

  // bits above VALUE_BITS are dropped
  assign val = push_value[VALUE_BITS-1:0];

  always_comb begin
    new_entry.value = val;
    if (empty || ($signed(val) < $signed(top_entry.min))) begin
      new_entry.min = val;
    end else begin
      new_entry.min = top_entry.min;
    end
  end

  always_comb begin
    fill_next = fill;
    res_entry = top_entry;
    if (do_push) begin
      fill_next = fill + CNT_BITS'(1);
      res_entry = new_entry;
    end else if (do_pop) begin
      fill_next = fill - CNT_BITS'(1);
      res_entry = next_entry;
    end
  end

  assign res_empty = (fill_next == '0);

  mts_chain u_chain (
    .clk        (clk),
    .shift      (shift),
    .new_entry  (new_entry),
    .top_entry  (top_entry),
    .next_entry (next_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        fill      <= fill_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, empty stack reads as zero
  always_ff @(posedge clk) begin
    if (in_fire) begin
      is_empty <= res_empty;
      op_error <= !(do_push || do_pop);
      if (res_empty) begin
        stack_top <= '0;
        stack_min <= '0;
      end else begin
        stack_top <= 32'($signed(res_entry.value));
        stack_min <= 32'($signed(res_entry.min));
      end
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_BITS'(DEPTH))
    else $error("fill count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (in_fire && do_push) |=> (fill == $past(fill) + CNT_BITS'(1)))
    else $error("push did not grow the stack");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (fill == '0)))
    else $error("empty flag disagrees with fill count");

  a_min_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_empty) |-> (stack_min <= stack_top))
    else $error("minimum above top value");
`endif

endmodule

/* design/mts_cell.sv */
// one stack cell: holds one entry, loads from the cell above on push
// and from the cell below on pop; uses mts_pkg
module mts_cell import mts_pkg::*; (
  input  logic   clk,
  input  shift_t shift,
  input  entry_t from_above,
  input  entry_t from_below,
  output entry_t entry
);

  always_ff @(posedge clk) begin
    if (shift.push) begin
      entry <= from_above;
    end else if (shift.pop) begin
      entry <= from_below;
    end
  end

endmodule

/* design/mts_chain.sv */
// row of DEPTH cells forming the stack, top entry in cell 0
// uses mts_pkg and mts_cell
module mts_chain import mts_pkg::*; (
  input  logic   clk,
  input  shift_t shift,
  input  entry_t new_entry,
  output entry_t top_entry,
  output entry_t next_entry
);

  entry_t cells [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t above;
    entry_t below;

    if (i == 0) begin : g_first
      assign above = new_entry;
    end else begin : g_inner_above
      assign above = cells[i-1];
    end

    // bottom cell takes filler on pop; it is beyond the fill count then
    if (i == DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_inner_below
      assign below = cells[i+1];
    end

    mts_cell u_cell (
      .clk        (clk),
      .shift      (shift),
      .from_above (above),
      .from_below (below),
      .entry      (cells[i])
    );
  end

  assign top_entry  = cells[0];
  assign next_entry = cells[1];

endmodule
